// File: rtl/tgq_pkg.sv
// Package: sizes, codes and controller/datapath link types for the team queue
`timescale 1ns / 1ps
package tgq_pkg;

    localparam int ELEMENTS = 1024;
    localparam int TEAMS    = 64;
    localparam int EW       = $clog2(ELEMENTS);
    localparam int TW       = $clog2(TEAMS);
    localparam int CW       = $clog2(ELEMENTS) + 1;

    typedef enum logic [1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_VALID   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MS_UNASSIGNED = 2'd0,
        MS_AVAILABLE  = 2'd1,
        MS_QUEUED     = 2'd2,
        MS_DEQUEUED   = 2'd3
    } mstat_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic clr_step;
    } ctl_t;

    typedef struct packed {
        logic out_busy;
        logic clr_last;
        logic is_clear;
    } dp_stat_t;

endpackage

// File: rtl/tgq_if.sv
// Channel interfaces: command beats in, response beats out
`timescale 1ns / 1ps
interface tgq_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [tgq_pkg::EW-1:0]    element_id;
    logic [tgq_pkg::TW-1:0]    team_id;

    modport source (output valid, command, element_id, team_id, input ready);
    modport sink   (input valid, command, element_id, team_id, output ready);
endinterface

interface tgq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [tgq_pkg::EW-1:0]    dequeued_element;

    modport source (output valid, status, dequeued_element, input ready);
    modport sink   (input valid, status, dequeued_element, output ready);
endinterface

// File: rtl/tgq_ctrl.sv
// Controller: sequences lookup reads, the update cycle and the clearing pass
`timescale 1ns / 1ps
module tgq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tgq_pkg::dp_stat_t stat,
    output tgq_pkg::ctl_t     ctl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ1 = 6'b000010,
        S_READ2 = 6'b000100,
        S_READ3 = 6'b001000,
        S_EXEC  = 6'b010000,
        S_CLR   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        req_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready  = 1'b1;
                ctl.accept = req_valid;
                if (req_valid)
                    state_next = S_READ1;
            end
            S_READ1: state_next = S_READ2;
            S_READ2: state_next = S_READ3;
            S_READ3: state_next = S_EXEC;
            S_EXEC:
            begin
                // hold until the response register is free
                if (!stat.out_busy)
                begin
                    ctl.exec   = 1'b1;
                    state_next = stat.is_clear ? S_CLR : S_IDLE;
                end
            end
            S_CLR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: rtl/tgq_dp.sv
// Datapath: membership and list memories, team ring, counters, response register
`timescale 1ns / 1ps
module tgq_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tgq_pkg::ctl_t          ctl,
    output tgq_pkg::dp_stat_t      stat,
    input  logic [1:0]             command,
    input  logic [tgq_pkg::EW-1:0] element_id,
    input  logic [tgq_pkg::TW-1:0] team_id,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [2:0]             status,
    output logic [tgq_pkg::EW-1:0] dequeued_element
);

    localparam int EW = tgq_pkg::EW;
    localparam int TW = tgq_pkg::TW;
    localparam int CW = tgq_pkg::CW;

    logic [1:0]  mstat_mem [tgq_pkg::ELEMENTS];
    logic [TW-1:0] mteam_mem [tgq_pkg::ELEMENTS];
    logic [EW-1:0] nxt_mem   [tgq_pkg::ELEMENTS];
    logic [EW-1:0] first_mem [tgq_pkg::TEAMS];
    logic [EW-1:0] last_mem  [tgq_pkg::TEAMS];
    logic [TW-1:0] order_mem [tgq_pkg::TEAMS];

    logic [1:0]    cmd_reg;
    logic [EW-1:0] e_reg;
    logic [TW-1:0] t_reg;
    logic [1:0]    mstat_q;
    logic [TW-1:0] mteam_q;
    logic [TW-1:0] order_q;
    logic [EW-1:0] first_q;
    logic [EW-1:0] last_q;
    logic [EW-1:0] nxt_q;

    logic [tgq_pkg::TEAMS-1:0] waiting_reg, waiting_next;
    logic [TW-1:0] rp_reg, rp_next;
    logic [TW-1:0] wp_reg, wp_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] clr_idx_reg;
    logic          rsp_valid_reg;
    logic [2:0]    status_reg;
    logic [EW-1:0] elem_reg;

    logic [TW-1:0] tsel;
    logic [2:0]    st_c;
    logic [EW-1:0] elem_c;
    logic          mstat_we;
    logic [EW-1:0] mstat_wa;
    logic [1:0]    mstat_wd;
    logic          mteam_we;
    logic          nxt_we;
    logic          first_we;
    logic [EW-1:0] first_wd;
    logic          last_we;
    logic          order_we;

    assign tsel = (cmd_reg == tgq_pkg::CMD_ENQUEUE) ? mteam_q : order_q;

    // latch the command beat
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= command;
            e_reg   <= element_id;
            t_reg   <= team_id;
        end
    end

    // registered memory reads, chained: member -> team ends -> successor
    always_ff @(posedge clk)
    begin
        mstat_q <= mstat_mem[e_reg];
        mteam_q <= mteam_mem[e_reg];
        order_q <= order_mem[rp_reg];
        first_q <= first_mem[tsel];
        last_q  <= last_mem[tsel];
        nxt_q   <= nxt_mem[first_q];
    end

    always_comb
    begin
        st_c         = tgq_pkg::ST_DONE;
        elem_c       = '0;
        mstat_we     = 1'b0;
        mstat_wa     = e_reg;
        mstat_wd     = tgq_pkg::MS_UNASSIGNED;
        mteam_we     = 1'b0;
        nxt_we       = 1'b0;
        first_we     = 1'b0;
        first_wd     = e_reg;
        last_we      = 1'b0;
        order_we     = 1'b0;
        waiting_next = waiting_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        count_next   = count_reg;
        case (cmd_reg)
            tgq_pkg::CMD_ASSIGN:
            begin
                if (mstat_q == tgq_pkg::MS_QUEUED)
                    st_c = tgq_pkg::ST_UNKNOWN;
                else
                begin
                    mteam_we = 1'b1;
                    mstat_we = 1'b1;
                    mstat_wd = tgq_pkg::MS_AVAILABLE;
                end
            end
            tgq_pkg::CMD_ENQUEUE:
            begin
                if (mstat_q != tgq_pkg::MS_AVAILABLE)
                    st_c = tgq_pkg::ST_UNKNOWN;
                else if (count_reg >= CW'(tgq_pkg::ELEMENTS))
                    st_c = tgq_pkg::ST_FULL;
                else
                begin
                    if (waiting_reg[tsel])
                    begin
                        nxt_we  = 1'b1;
                        last_we = 1'b1;
                    end
                    else
                    begin
                        first_we           = 1'b1;
                        last_we            = 1'b1;
                        waiting_next[tsel] = 1'b1;
                        order_we           = 1'b1;
                        wp_next = (wp_reg == TW'(tgq_pkg::TEAMS - 1)) ? '0 : wp_reg + 1'b1;
                    end
                    mstat_we   = 1'b1;
                    mstat_wd   = tgq_pkg::MS_QUEUED;
                    count_next = count_reg + 1'b1;
                end
            end
            tgq_pkg::CMD_DEQUEUE:
            begin
                if (count_reg == '0)
                    st_c = tgq_pkg::ST_EMPTY;
                else
                begin
                    st_c   = tgq_pkg::ST_VALID;
                    elem_c = first_q;
                    if (last_q == first_q)
                    begin
                        // team drained: drop it from the ring
                        waiting_next[tsel] = 1'b0;
                        rp_next = (rp_reg == TW'(tgq_pkg::TEAMS - 1)) ? '0 : rp_reg + 1'b1;
                    end
                    else
                    begin
                        first_we = 1'b1;
                        first_wd = nxt_q;
                    end
                    mstat_we   = 1'b1;
                    mstat_wa   = first_q;
                    mstat_wd   = tgq_pkg::MS_DEQUEUED;
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                waiting_next = '0;
                rp_next      = '0;
                wp_next      = '0;
                count_next   = '0;
            end
        endcase
        if (!ctl.exec)
        begin
            mstat_we = 1'b0;
            mteam_we = 1'b0;
            nxt_we   = 1'b0;
            first_we = 1'b0;
            last_we  = 1'b0;
            order_we = 1'b0;
        end
        // sweep of the clearing pass
        if (ctl.clr_step)
        begin
            mstat_we = 1'b1;
            mstat_wa = clr_idx_reg;
            mstat_wd = tgq_pkg::MS_UNASSIGNED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mstat_we)
            mstat_mem[mstat_wa] <= mstat_wd;
        if (mteam_we)
            mteam_mem[e_reg] <= t_reg;
        if (nxt_we)
            nxt_mem[last_q] <= e_reg;
        if (first_we)
            first_mem[tsel] <= first_wd;
        if (last_we)
            last_mem[tsel] <= e_reg;
        if (order_we)
            order_mem[wp_reg] <= tsel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg   <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            clr_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                waiting_reg   <= waiting_next;
                rp_reg        <= rp_next;
                wp_reg        <= wp_next;
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
            if (ctl.clr_step)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            else if (ctl.exec)
                clr_idx_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            status_reg <= st_c;
            elem_reg   <= elem_c;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign dequeued_element = elem_reg;

    assign stat.out_busy = rsp_valid_reg && !rsp_ready;
    assign stat.clr_last = (clr_idx_reg == EW'(tgq_pkg::ELEMENTS - 1));
    assign stat.is_clear = (cmd_reg == tgq_pkg::CMD_CLEAR);

    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && status_reg != tgq_pkg::ST_VALID |-> elem_reg == '0)
        else $error("dequeued element nonzero without valid status");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(tgq_pkg::ELEMENTS))
        else $error("queued count above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec && stat.is_clear |=> waiting_reg == '0 && count_reg == '0)
        else $error("clear left queued state");

    a_empty_no_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> waiting_reg == '0)
        else $error("team marked waiting on an empty queue");

endmodule

// File: rtl/team_grouped_queue_top.sv
// Team queue: a beat from IDLE passes READ1, READ2, READ3 (chained registered reads of
// member entry, team list ends, successor link) and EXEC, which sets the response once
// the previous one is taken; no beat enters until then. Reset and the clear command
// start a pass that zeroes the member status memory; no command beat is taken during
// it. Async active-low reset clears control state; the response may wait without loss.
`timescale 1ns / 1ps
module team_grouped_queue_top (
    input  logic      clk,
    input  logic      rst_n,
    tgq_req_if.sink   req,
    tgq_rsp_if.source rsp
);

    tgq_pkg::ctl_t     ctl;
    tgq_pkg::dp_stat_t stat;

    tgq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    tgq_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .command          (req.command),
        .element_id       (req.element_id),
        .team_id          (req.team_id),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .status           (rsp.status),
        .dequeued_element (rsp.dequeued_element)
    );

endmodule

// File: tb/team_grouped_queue_top_tb.sv
// Testbench for the team queue: directed and random command beats checked against a predictor
`timescale 1ns / 1ps
module team_grouped_queue_top_tb;

    localparam int N_RANDOM  = 710;
    localparam int HOLD_LEN  = 300;
    localparam int POOL_SIZE = 24;

    logic clk;
    logic rst_n;

    tgq_req_if req_ch();
    tgq_rsp_if rsp_ch();

    team_grouped_queue_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    typedef struct {
        tgq_pkg::status_t          status;
        logic [tgq_pkg::EW-1:0]    element;
    } answer_t;

    // predicted queue state
    logic [tgq_pkg::TW-1:0]  q_team [tgq_pkg::ELEMENTS];
    tgq_pkg::mstat_t         q_mstat [tgq_pkg::ELEMENTS];
    logic [tgq_pkg::EW-1:0]  q_next [tgq_pkg::ELEMENTS];
    logic [tgq_pkg::EW-1:0]  q_first [tgq_pkg::TEAMS];
    logic [tgq_pkg::EW-1:0]  q_last [tgq_pkg::TEAMS];
    logic                    q_waiting [tgq_pkg::TEAMS];
    logic [tgq_pkg::TW-1:0]  q_order [tgq_pkg::TEAMS];
    logic [tgq_pkg::TW-1:0]  q_rd;
    logic [tgq_pkg::TW-1:0]  q_wr;
    int                      q_count;

    answer_t pending_answers[$];

    int  n_sent;
    int  n_checked;
    int  n_popped;
    int  n_errors;
    bit  timed_out;
    int  burst_left;
    bit  hold_go;
    int  hold_cnt;
    int  stall_mode;

    logic [tgq_pkg::EW-1:0] elem_pool [POOL_SIZE];
    logic [tgq_pkg::TW-1:0] team_pool [4];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void wipe_queue();
        for (int i = 0; i < tgq_pkg::ELEMENTS; i++)
        begin
            q_mstat[i] = tgq_pkg::MS_UNASSIGNED;
            q_team[i]  = '0;
            q_next[i]  = '0;
        end
        for (int i = 0; i < tgq_pkg::TEAMS; i++)
        begin
            q_first[i]   = '0;
            q_last[i]    = '0;
            q_waiting[i] = 1'b0;
            q_order[i]   = '0;
        end
        q_rd    = '0;
        q_wr    = '0;
        q_count = 0;
    endfunction

    function automatic answer_t queue_answer(tgq_pkg::cmd_t cmd, logic [tgq_pkg::EW-1:0] e,
                                             logic [tgq_pkg::TW-1:0] t);
        answer_t                a;
        logic [tgq_pkg::TW-1:0] tm;
        a.status  = tgq_pkg::ST_DONE;
        a.element = '0;
        case (cmd)
            tgq_pkg::CMD_ASSIGN:
            begin
                if (q_mstat[e] == tgq_pkg::MS_QUEUED)
                    a.status = tgq_pkg::ST_UNKNOWN;
                else
                begin
                    q_team[e]  = t;
                    q_mstat[e] = tgq_pkg::MS_AVAILABLE;
                end
            end
            tgq_pkg::CMD_ENQUEUE:
            begin
                if (q_mstat[e] != tgq_pkg::MS_AVAILABLE)
                    a.status = tgq_pkg::ST_UNKNOWN;
                else if (q_count >= tgq_pkg::ELEMENTS)
                    a.status = tgq_pkg::ST_FULL;
                else
                begin
                    tm = q_team[e];
                    if (q_waiting[tm])
                    begin
                        q_next[q_last[tm]] = e;
                        q_last[tm] = e;
                    end
                    else
                    begin
                        q_first[tm]   = e;
                        q_last[tm]    = e;
                        q_waiting[tm] = 1'b1;
                        q_order[q_wr] = tm;
                        q_wr = q_wr + 1'b1;
                    end
                    q_mstat[e] = tgq_pkg::MS_QUEUED;
                    q_count++;
                end
            end
            tgq_pkg::CMD_DEQUEUE:
            begin
                if (q_count == 0)
                    a.status = tgq_pkg::ST_EMPTY;
                else
                begin
                    tm = q_order[q_rd];
                    a.element = q_first[tm];
                    a.status  = tgq_pkg::ST_VALID;
                    if (q_last[tm] == a.element)
                    begin
                        q_waiting[tm] = 1'b0;
                        q_rd = q_rd + 1'b1;
                    end
                    else
                        q_first[tm] = q_next[a.element];
                    q_mstat[a.element] = tgq_pkg::MS_DEQUEUED;
                    q_count--;
                end
            end
            default:
                wipe_queue();
        endcase
        return a;
    endfunction

    // call at a rising edge; returns at the edge where the beat was taken, or after a random idle gap
    task automatic send_cmd(tgq_pkg::cmd_t cmd, logic [tgq_pkg::EW-1:0] e,
                            logic [tgq_pkg::TW-1:0] t);
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.element_id <= e;
        req_ch.team_id    <= t;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_answers.push_back(queue_answer(cmd, e, t));
        n_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic refresh_pools();
        for (int i = 0; i < POOL_SIZE; i++)
            elem_pool[i] = tgq_pkg::EW'($urandom_range(0, tgq_pkg::ELEMENTS - 1));
        for (int i = 0; i < 4; i++)
            team_pool[i] = tgq_pkg::TW'($urandom_range(0, tgq_pkg::TEAMS - 1));
    endtask

    task automatic test_directed();
        send_cmd(tgq_pkg::CMD_DEQUEUE, '0, '0);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd5, '0);
        send_cmd(tgq_pkg::CMD_ASSIGN, 10'd0, 6'd0);
        send_cmd(tgq_pkg::CMD_ASSIGN, 10'd1023, 6'd63);
        send_cmd(tgq_pkg::CMD_ASSIGN, 10'd512, 6'd0);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd0, '0);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd1023, '0);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd0, '0);
        send_cmd(tgq_pkg::CMD_ASSIGN, 10'd0, 6'd5);
        // teammate jumps ahead of team 63
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd512, '0);
        send_cmd(tgq_pkg::CMD_DEQUEUE, '0, '0);
        send_cmd(tgq_pkg::CMD_DEQUEUE, '0, '0);
        send_cmd(tgq_pkg::CMD_DEQUEUE, '0, '0);
        send_cmd(tgq_pkg::CMD_DEQUEUE, '0, '0);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd1023, '0);
        send_cmd(tgq_pkg::CMD_ASSIGN, 10'd1023, 6'd42);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd1023, '0);
        send_cmd(tgq_pkg::CMD_CLEAR, 10'd1023, 6'd63);
        send_cmd(tgq_pkg::CMD_ENQUEUE, 10'd1023, '0);
        send_cmd(tgq_pkg::CMD_DEQUEUE, '0, '0);
        drain();
    endtask

    task automatic random_cmd();
        int                     pick;
        logic [tgq_pkg::EW-1:0] e;
        logic [tgq_pkg::TW-1:0] t;
        pick = $urandom_range(0, 199);
        e = elem_pool[$urandom_range(0, POOL_SIZE - 1)];
        t = team_pool[$urandom_range(0, 3)];
        if (pick < 70)
            send_cmd(tgq_pkg::CMD_ASSIGN, e, t);
        else if (pick < 140)
            send_cmd(tgq_pkg::CMD_ENQUEUE, e, tgq_pkg::TW'($urandom));
        else if (pick < 188)
            send_cmd(tgq_pkg::CMD_DEQUEUE, tgq_pkg::EW'($urandom), tgq_pkg::TW'($urandom));
        else if (pick < 198)
            send_cmd(tgq_pkg::cmd_t'($urandom_range(0, 2)), tgq_pkg::EW'($urandom),
                     tgq_pkg::TW'($urandom));
        else
        begin
            send_cmd(tgq_pkg::CMD_CLEAR, tgq_pkg::EW'($urandom), tgq_pkg::TW'($urandom));
            refresh_pools();
        end
    endtask

    task automatic test_random();
        refresh_pools();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 200 == 0)
                stall_mode = $urandom_range(0, 2);
            random_cmd();
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_go <= 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            burst_left = 5;
            send_cmd(tgq_pkg::CMD_ASSIGN, tgq_pkg::EW'(i), tgq_pkg::TW'(i % 3));
            send_cmd(tgq_pkg::CMD_ENQUEUE, tgq_pkg::EW'(i), '0);
        end
        hold_go <= 1'b0;
        drain();
    endtask

    // receiver ready: own stall pattern, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt     <= 0;
        end
        else if (hold_go && hold_cnt < HOLD_LEN)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end
        else
        begin
            if (!hold_go)
                hold_cnt <= 0;
            case (stall_mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected response: status %0d element %0d",
                             rsp_ch.status, rsp_ch.dequeued_element);
            end
            else
            begin
                answer_t a;
                a = pending_answers.pop_front();
                n_checked++;
                if (a.status == tgq_pkg::ST_VALID)
                    n_popped++;
                if (rsp_ch.status !== a.status || rsp_ch.dequeued_element !== a.element)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch at response %0d: expected %0d/%0d, got %0d/%0d",
                                 n_checked, a.status, a.element,
                                 rsp_ch.status, rsp_ch.dequeued_element);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        timed_out = 1'b1;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = tgq_pkg::CMD_ASSIGN;
        req_ch.element_id = '0;
        req_ch.team_id    = '0;
        hold_go           = 1'b0;
        stall_mode        = 1;
        burst_left        = 0;
        n_sent            = 0;
        n_checked         = 0;
        n_popped          = 0;
        n_errors          = 0;
        timed_out         = 1'b0;
        wipe_queue();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();
        stall_mode = 0;
        test_backpressure();

        if (pending_answers.size() != 0)
            n_errors++;
        $display("commands sent %0d, responses checked %0d, elements dequeued %0d",
                 n_sent, n_checked, n_popped);
        $display("covered assign/enqueue/dequeue/clear, error codes, and a long output stall");
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
